### src/slot_alloc_pkg.sv
`timescale 1ns / 1ps
package slot_alloc_pkg;

  // Default table geometry
  localparam int unsigned SLOTS_DEF    = 1024;
  localparam int unsigned TAG_BITS_DEF = 16;

  // Occupancy bitmap is scanned one word per read
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_IDX_W = 5;

  // Port field widths
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned ITEM_W    = 16;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CNT_OUT_W = 11;

  // Request actions; the remaining code is rejected as invalid
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_AT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_INVALID  = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_RD,
    S_EVAL,
    S_DONE
  } state_t;

  // Index of the lowest set bit (0 when none is set)
  function automatic logic [WORD_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### src/slot_allocator_next_free_top.sv
`timescale 1ns / 1ps
// Slot allocator with a next-free hint. Each slot holds an occupied bit (in a
// word-wide bitmap memory) and an item tag (in a tag memory). An add takes the
// hint slot (or a named slot that must match a nonzero hint), then the bitmap
// is scanned for the next free slot, first upward from the slot just taken and
// then from slot 0 up to the old hint; if nothing is free the add is dropped
// and no-space is reported. A remove frees a slot whose tag matches and points
// the hint at it. One request is worked on at a time: a remove or a rejected
// request passes the look and check states only; an add then scans the bitmap
// word by word (32 bits each), each word read in S_RD and weighed in S_EVAL,
// through the single bitmap read port. After reset the bitmap is cleared one
// word per cycle, during which in_ready stays low. The result sits in an
// output register, so a new request is taken while it waits.
module slot_allocator_next_free_top
  import slot_alloc_pkg::*;
#(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [ITEM_W-1:0]    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [SLOT_W-1:0]    out_assigned_slot,
  output logic [CNT_OUT_W-1:0] out_used_count,
  output logic [SLOT_W-1:0]    out_next_free
);

  localparam int unsigned ROWS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned XW        = ROW_W + WORD_IDX_W;
  localparam int unsigned TW        = $clog2(SLOTS);
  localparam int unsigned CW        = $clog2(SLOTS + 1);
  localparam int unsigned LAST_BITS = SLOTS - (ROWS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - LAST_BITS);
  localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(ROWS - 1);

  // Control state
  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;          // clear pointer / scan word
  logic                wrap_r, wrap_nxt;        // scan is in the wrap part
  logic [XW-1:0]       hint_r, hint_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request and result
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [XW-1:0]       s_r, s_nxt;              // target slot
  logic                rng_r, rng_nxt;          // target slot inside table
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [WORD_BITS-1:0] srow_r, srow_nxt;       // bitmap word holding target
  status_t             res_status_r, res_status_nxt;
  logic [XW-1:0]       res_slot_r, res_slot_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [XW-1:0]       out_slot_r, out_slot_nxt;
  logic [CW-1:0]       out_cnt_r, out_cnt_nxt;
  logic [XW-1:0]       out_hint_r, out_hint_nxt;

  // Memories
  logic [WORD_BITS-1:0] bm_mem [ROWS];
  logic [TAG_BITS-1:0]  tag_mem [SLOTS];
  logic [WORD_BITS-1:0] bm_rd_r;
  logic [TAG_BITS-1:0]  tag_rd_r;
  logic                 bm_we, tag_we;
  logic [ROW_W-1:0]     bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata;

  // Decode
  logic                  in_acc, out_free;
  logic [ROW_W-1:0]      s_row, h_row;
  logic [WORD_IDX_W-1:0] s_bit, h_bit;
  logic [WORD_BITS-1:0]  s_onehot;
  logic                  chk_bit, hint_zero, chk_place, rm_hit;
  logic [WORD_BITS-1:0]  free_v, elig_v, cand_v;
  logic                  cand_any, scan_end;

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign s_row     = s_r[XW-1:WORD_IDX_W];
  assign s_bit     = s_r[WORD_IDX_W-1:0];
  assign h_row     = hint_r[XW-1:WORD_IDX_W];
  assign h_bit     = hint_r[WORD_IDX_W-1:0];
  assign s_onehot  = WORD_BITS'(1) << s_bit;
  assign chk_bit   = bm_rd_r[s_bit];
  assign hint_zero = (hint_r == '0);

  // Add-at needs a free in-range slot equal to the hint unless the hint is zero
  assign chk_place = (act_r == ACT_ADD && !chk_bit) ||
                     (act_r == ACT_ADD_AT && rng_r && !chk_bit &&
                      (hint_zero || hint_r == s_r));
  assign rm_hit    = (act_r == ACT_REMOVE) && rng_r && chk_bit && (tag_rd_r == tag_r);

  // Scan word: free bits past the table end count as taken. Upward part keeps
  // bits above the target slot; wrap part keeps bits below the old hint.
  assign free_v = ~bm_rd_r & ((row_r == LAST_ROW) ? LAST_MASK : ONES);
  always_comb begin
    if (!wrap_r) begin
      elig_v = (row_r == s_row) ? ((ONES << s_bit) << 1) : ONES;
    end else begin
      elig_v = (row_r == h_row) ? ~(ONES << h_bit) : ONES;
    end
  end
  assign cand_v   = free_v & elig_v;
  assign cand_any = |cand_v;
  assign scan_end = wrap_r ? (row_r == h_row) : (row_r == LAST_ROW && hint_zero);

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_slot = SLOT_W'(out_slot_r);
  assign out_used_count    = CNT_OUT_W'(out_cnt_r);
  assign out_next_free     = SLOT_W'(out_hint_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (row_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = chk_place ? S_RD : S_DONE;
      S_RD:    state_nxt = S_EVAL;
      S_EVAL:  state_nxt = (cand_any || scan_end) ? S_DONE : S_RD;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    row_nxt        = row_r;
    wrap_nxt       = wrap_r;
    hint_nxt       = hint_r;
    cnt_nxt        = cnt_r;
    act_nxt        = act_r;
    s_nxt          = s_r;
    rng_nxt        = rng_r;
    tag_nxt        = tag_r;
    srow_nxt       = srow_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_cnt_nxt    = out_cnt_r;
    out_hint_nxt   = out_hint_r;
    bm_we          = 1'b0;
    bm_waddr       = s_row;
    bm_wdata       = '0;
    tag_we         = 1'b0;
    bm_raddr       = (state_r == S_RD) ? row_r : s_row;

    case (state_r)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = row_r;
        row_nxt  = row_r + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt = in_action;
          s_nxt   = (in_action == ACT_ADD) ? hint_r : XW'(in_slot);
          rng_nxt = (in_action == ACT_ADD) || (32'(in_slot) < 32'(SLOTS));
          tag_nxt = TAG_BITS'(in_item);
        end
      end
      S_CHECK: begin
        res_slot_nxt = '0;
        if (chk_place) begin
          tag_we   = 1'b1;
          srow_nxt = bm_rd_r;
          row_nxt  = s_row;
          wrap_nxt = 1'b0;
        end else if (rm_hit) begin
          bm_we          = 1'b1;
          bm_wdata       = bm_rd_r & ~s_onehot;
          hint_nxt       = s_r;
          cnt_nxt        = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
          res_status_nxt = ST_OK;
        end else begin
          case (act_r)
            ACT_ADD:    res_status_nxt = ST_EXISTS;
            ACT_ADD_AT: res_status_nxt = (rng_r && chk_bit) ? ST_EXISTS : ST_INVALID;
            ACT_REMOVE: res_status_nxt = ST_NOTFOUND;
            default:    res_status_nxt = ST_INVALID;
          endcase
        end
      end
      S_EVAL: begin
        if (cand_any) begin
          // commit the add only once a next free slot is known
          bm_we          = 1'b1;
          bm_wdata       = srow_r | s_onehot;
          hint_nxt       = {row_r, lowest_set(cand_v)};
          cnt_nxt        = cnt_r + 1'b1;
          res_status_nxt = ST_OK;
          res_slot_nxt   = s_r;
        end else if (scan_end) begin
          res_status_nxt = ST_NOSPACE;
        end else if (!wrap_r && row_r == LAST_ROW) begin
          wrap_nxt = 1'b1;
          row_nxt  = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_cnt_nxt    = cnt_r;
          out_hint_nxt   = hint_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      wrap_r      <= 1'b0;
      hint_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      wrap_r      <= wrap_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    s_r          <= s_nxt;
    rng_r        <= rng_nxt;
    tag_r        <= tag_nxt;
    srow_r       <= srow_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_hint_r   <= out_hint_nxt;
  end

  // Occupancy bitmap, one word per row
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_rd_r <= bm_mem[bm_raddr];
  end

  // Item tags
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[s_r[TW-1:0]] <= tag_r;
    end
    tag_rd_r <= tag_mem[s_r[TW-1:0]];
  end

  // One slot always stays free, so the count never reaches the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CW'(SLOTS))
    else $error("used count reached table size");

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hint_r) < 32'(SLOTS))
    else $error("next-free hint outside table");

  // Wrap part of the scan never runs past the word holding the old hint
  a_wrap_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && wrap_r) |-> (row_r <= h_row))
    else $error("wrap scan past hint word");

  // A successful add leaves the hint on a slot other than the one just taken
  a_add_moves_hint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && cand_any) |=> (hint_r != s_r))
    else $error("hint left on newly taken slot");

endmodule

### dv/slot_allocator_next_free_top_tb.sv
`timescale 1ns / 1ps
// Slot allocator testbench.
// A directed table walks the corner cases from reset. Three random phases
// follow: a mixed phase, a fill phase that pushes the table into no-space,
// and a drain phase. Every accepted request runs through a local model of
// the table. Each result is checked field by field against the oldest
// expectation.
module slot_allocator_next_free_top_tb;
  import slot_alloc_pkg::*;

  localparam int unsigned TABLE_SLOTS = SLOTS_DEF;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;  // unused code, rejected
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT = 100;        // past the worst add scan
  localparam int unsigned DIR_ROWS = 20;

  // One result as the block reports it
  typedef struct packed {
    status_t                status;
    logic [SLOT_W-1:0]      assigned_slot;
    logic [CNT_OUT_W-1:0]   used_count;
    logic [SLOT_W-1:0]      next_free;
  } alloc_result_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [SLOT_W-1:0] slot;
    logic [ITEM_W-1:0] item;
    logic              typed;
    alloc_result_t     want;
  } alloc_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action;
  logic [SLOT_W-1:0]    in_slot;
  logic [ITEM_W-1:0]    in_item;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic [SLOT_W-1:0]    out_assigned_slot;
  logic [CNT_OUT_W-1:0] out_used_count;
  logic [SLOT_W-1:0]    out_next_free;

  slot_allocator_next_free_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_slot           (in_slot),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_assigned_slot (out_assigned_slot),
    .out_used_count    (out_used_count),
    .out_next_free     (out_next_free)
  );

  // Model of the table: occupancy, tags, count and hint
  bit                slot_busy    [TABLE_SLOTS];
  bit                slot_written [TABLE_SLOTS];  // tag holds a known value
  logic [ITEM_W-1:0] slot_tag     [TABLE_SLOTS];
  int unsigned       used_total;
  int unsigned       free_hint;
  int unsigned       peak_used;

  alloc_result_t results_due[$];  // one per accepted request, oldest first
  int unsigned   status_hits[5];
  int unsigned   requests_sent;
  int unsigned   results_checked;
  int unsigned   mismatches;
  int unsigned   cycles;

  bit sender_idles;
  bit receiver_stalls;

  alloc_row_t dir_rows [DIR_ROWS];

  // Free slot search: upward from start, then over [0, wrap_end)
  function automatic bit find_free_slot(input int unsigned start,
                                        input int unsigned wrap_end,
                                        output int unsigned found);
    found = 0;
    for (int unsigned i = start; i < TABLE_SLOTS; i++) begin
      if (!slot_busy[i]) begin
        found = i;
        return 1'b1;
      end
    end
    for (int unsigned i = 0; i < wrap_end && i < TABLE_SLOTS; i++) begin
      if (!slot_busy[i]) begin
        found = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Take slot s; back out when the search finds nothing free
  function automatic status_t take_slot(input int unsigned s, input logic [ITEM_W-1:0] tag,
                                        input int unsigned old_hint);
    int unsigned nf;
    slot_busy[s] = 1'b1;
    slot_tag[s]  = tag;
    used_total++;
    if (!find_free_slot(s, old_hint, nf)) begin
      slot_busy[s] = 1'b0;
      used_total--;
      return ST_NOSPACE;
    end
    // only a kept add is trusted to have written the tag store
    slot_written[s] = 1'b1;
    free_hint = nf;
    if (used_total > peak_used) begin
      peak_used = used_total;
    end
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_alloc(input logic [ACT_W-1:0] act,
                                                  input logic [SLOT_W-1:0] slot,
                                                  input logic [ITEM_W-1:0] item);
    alloc_result_t r;
    int unsigned h;
    h = free_hint;
    r.status = ST_INVALID;
    r.assigned_slot = '0;
    case (act)
      ACT_ADD: begin
        if (slot_busy[h]) begin
          r.status = ST_EXISTS;
        end else begin
          r.status = take_slot(h, item, h);
          if (r.status == ST_OK) begin
            r.assigned_slot = SLOT_W'(h);
          end
        end
      end
      ACT_ADD_AT: begin
        if (slot_busy[slot]) begin
          r.status = ST_EXISTS;
        end else if (h != 0 && h != slot) begin
          r.status = ST_INVALID;  // named slot must match a nonzero hint
        end else begin
          r.status = take_slot(slot, item, h);
          if (r.status == ST_OK) begin
            r.assigned_slot = slot;
          end
        end
      end
      ACT_REMOVE: begin
        if (slot_busy[slot] && slot_tag[slot] == item) begin
          slot_busy[slot] = 1'b0;
          free_hint = slot;
          if (used_total > 0) begin
            used_total--;
          end
          r.status = ST_OK;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    r.used_count = CNT_OUT_W'(used_total);
    r.next_free  = SLOT_W'(free_hint);
    status_hits[r.status]++;
    return r;
  endfunction

  // Random slot that is occupied (want_busy) or has a known tag; -1 if none
  function automatic int pick_slot(input bit want_busy);
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, TABLE_SLOTS - 1);
    for (int unsigned k = 0; k < TABLE_SLOTS; k++) begin
      idx = (start + k) % TABLE_SLOTS;
      if (want_busy ? slot_busy[idx] : slot_written[idx]) begin
        return int'(idx);
      end
    end
    return -1;
  endfunction

  // Random request: adds and clean removes in the given mix, the rest noise.
  // Removes only ever target slots whose tag is known.
  task automatic next_request(input int unsigned add_pct, input int unsigned rm_pct,
                              output logic [ACT_W-1:0] act,
                              output logic [SLOT_W-1:0] slot,
                              output logic [ITEM_W-1:0] item);
    int unsigned r;
    int found;
    r = $urandom_range(0, 99);
    act  = ACT_ADD;
    slot = SLOT_W'($urandom);
    item = ITEM_W'($urandom);
    if (r < add_pct) begin
      if ($urandom_range(0, 3) == 0) begin
        act = ACT_ADD_AT;
        // zero hint lets any slot through, so keep the random one then
        if (free_hint != 0) begin
          slot = SLOT_W'(free_hint);
        end
      end
    end else if (r < add_pct + rm_pct) begin
      found = pick_slot(1'b1);
      if (found >= 0) begin
        act  = ACT_REMOVE;
        slot = SLOT_W'(found);
        item = slot_tag[found];
      end
    end else begin
      case ($urandom_range(0, 3))
        0: act = ACT_UNUSED;
        1: act = ACT_ADD_AT;  // random slot: mostly off the hint or taken
        default: begin
          found = pick_slot(1'b0);
          if (found < 0) begin
            act = ACT_UNUSED;
          end else begin
            act  = ACT_REMOVE;
            slot = SLOT_W'(found);
            // near miss on the tag: one bit flipped
            if (slot_busy[found] && $urandom_range(0, 1) == 1) begin
              item = slot_tag[found] ^ ITEM_W'(1 << $urandom_range(0, ITEM_W - 1));
            end
          end
        end
      endcase
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] slot,
                              input logic [ITEM_W-1:0] item, input bit typed,
                              input alloc_result_t want);
    alloc_result_t got;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_action = act;
    in_slot   = slot;
    in_item   = item;
    do @(posedge clk); while (!in_ready);
    got = predict_alloc(act, slot, item);
    results_due.push_back(typed ? want : got);
    requests_sent++;
    @(negedge clk);
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Receiver: stall bursts of random length while enabled
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: status %0d slot %0d",
               out_status, out_assigned_slot);
        mismatches++;
      end else begin
        exp_r = results_due.pop_front();
        results_checked++;
        if (out_status !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, out_status);
          mismatches++;
        end
        if (out_assigned_slot !== exp_r.assigned_slot) begin
          $error("assigned_slot mismatch: expected %0d, got %0d",
                 exp_r.assigned_slot, out_assigned_slot);
          mismatches++;
        end
        if (out_used_count !== exp_r.used_count) begin
          $error("used_count mismatch: expected %0d, got %0d",
                 exp_r.used_count, out_used_count);
          mismatches++;
        end
        if (out_next_free !== exp_r.next_free) begin
          $error("next_free mismatch: expected %0d, got %0d",
                 exp_r.next_free, out_next_free);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [ACT_W-1:0]  act;
    logic [SLOT_W-1:0] slot;
    logic [ITEM_W-1:0] item;
    int unsigned       fill_count;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_ADD;
    in_slot = '0;
    in_item = '0;
    cycles = 0;
    used_total = 0;
    free_hint = 0;
    peak_used = 0;
    requests_sent = 0;
    results_checked = 0;
    mismatches = 0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < 5; i++) begin
      status_hits[i] = 0;
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_written[i] = 1'b0;
      slot_tag[i] = '0;
    end

    // Directed walk from reset. Expected values are (status, slot, count, hint).
    dir_rows[0]  = '{ACT_ADD,    10'd777,  16'hFFFF, 1'b1, '{ST_OK,       10'd0,    11'd1, 10'd1}};
    dir_rows[1]  = '{ACT_UNUSED, 10'd1023, 16'h0000, 1'b1, '{ST_INVALID,  10'd0,    11'd1, 10'd1}};
    // add-at on a taken slot, then off the hint
    dir_rows[2]  = '{ACT_ADD_AT, 10'd0,    16'h0001, 1'b1, '{ST_EXISTS,   10'd0,    11'd1, 10'd1}};
    dir_rows[3]  = '{ACT_ADD_AT, 10'd5,    16'h0002, 1'b1, '{ST_INVALID,  10'd0,    11'd1, 10'd1}};
    dir_rows[4]  = '{ACT_ADD_AT, 10'd1,    16'h0000, 1'b1, '{ST_OK,       10'd1,    11'd2, 10'd2}};
    // remove: tag mismatch, hit (hint drops to 0), then slot already free
    dir_rows[5]  = '{ACT_REMOVE, 10'd0,    16'h1234, 1'b1, '{ST_NOTFOUND, 10'd0,    11'd2, 10'd2}};
    dir_rows[6]  = '{ACT_REMOVE, 10'd0,    16'hFFFF, 1'b1, '{ST_OK,       10'd0,    11'd1, 10'd0}};
    dir_rows[7]  = '{ACT_REMOVE, 10'd0,    16'hFFFF, 1'b1, '{ST_NOTFOUND, 10'd0,    11'd1, 10'd0}};
    // zero hint: no wrap search, so the top slot alone finds no space
    dir_rows[8]  = '{ACT_ADD_AT, 10'd1023, 16'hC3C3, 1'b1, '{ST_NOSPACE,  10'd0,    11'd1, 10'd0}};
    dir_rows[9]  = '{ACT_ADD_AT, 10'd1022, 16'hA5A5, 1'b1, '{ST_OK,       10'd1022, 11'd2, 10'd1023}};
    // add at the top slot wraps the search down to slot 0
    dir_rows[10] = '{ACT_ADD,    10'd0,    16'h5A5A, 1'b1, '{ST_OK,       10'd1023, 11'd3, 10'd0}};
    dir_rows[11] = '{ACT_REMOVE, 10'd1023, 16'h5A5A, 1'b1, '{ST_OK,       10'd0,    11'd2, 10'd1023}};
    dir_rows[12] = '{ACT_REMOVE, 10'd1022, 16'hA5A4, 1'b1, '{ST_NOTFOUND, 10'd0,    11'd2, 10'd1023}};
    dir_rows[13] = '{ACT_REMOVE, 10'd1022, 16'hA5A5, 1'b1, '{ST_OK,       10'd0,    11'd1, 10'd1022}};
    dir_rows[14] = '{ACT_REMOVE, 10'd1023, 16'h5A5A, 1'b1, '{ST_NOTFOUND, 10'd0,    11'd1, 10'd1022}};
    dir_rows[15] = '{ACT_UNUSED, 10'd0,    16'hFFFF, 1'b1, '{ST_INVALID,  10'd0,    11'd1, 10'd1022}};
    dir_rows[16] = '{ACT_ADD_AT, 10'd1022, 16'h8001, 1'b1, '{ST_OK,       10'd1022, 11'd2, 10'd1023}};
    dir_rows[17] = '{ACT_REMOVE, 10'd1,    16'h0000, 1'b1, '{ST_OK,       10'd0,    11'd1, 10'd1}};
    // from here the model decides
    dir_rows[18] = '{ACT_ADD,    10'd512,  16'h1357, 1'b0, '0};
    dir_rows[19] = '{ACT_ADD_AT, 10'd2,    16'h7FFE, 1'b0, '0};

    // Hold reset, then release it; the block then clears its bitmap with in_ready low
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_rows[i].act, dir_rows[i].slot, dir_rows[i].item,
                   dir_rows[i].typed, dir_rows[i].want);
    end
    wait_results_drained();

    // Mixed traffic at low occupancy
    for (int i = 0; i < 150; i++) begin
      next_request(45, 35, act, slot, item);
      send_request(act, slot, item, 1'b0, '0);
    end

    // Fill until full and no-space has been hit several times; idling comes
    // and goes in stretches of 128 requests
    fill_count = 0;
    while (fill_count < 1300 &&
           !(used_total == TABLE_SLOTS - 1 && status_hits[ST_NOSPACE] >= 8)) begin
      sender_idles    = ((fill_count / 128) % 2) == 0;
      receiver_stalls = ((fill_count / 128) % 2) == 1;
      next_request(96, 2, act, slot, item);
      send_request(act, slot, item, 1'b0, '0);
      fill_count++;
    end
    wait_results_drained();

    // Drain, with idling only in the first half
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < 200; i++) begin
      if (i == 100) begin
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
      end
      next_request(25, 60, act, slot, item);
      send_request(act, slot, item, 1'b0, '0);
    end

    wait_results_drained();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("summary: %0d requests, %0d results checked, peak occupancy %0d of %0d",
             requests_sent, results_checked, peak_used, TABLE_SLOTS);
    $display("summary: ok %0d, exists %0d, invalid %0d, no-space %0d, not-found %0d",
             status_hits[ST_OK], status_hits[ST_EXISTS], status_hits[ST_INVALID],
             status_hits[ST_NOSPACE], status_hits[ST_NOTFOUND]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### slot_allocator_next_free_top.f
src/slot_alloc_pkg.sv
src/slot_allocator_next_free_top.sv
dv/slot_allocator_next_free_top_tb.sv
